[sv/npr_pkg.sv]
// npr_pkg: shared types, constants and codes for the nearest-point ray pick.
// No dependencies; every other file of the block imports it.
package npr_pkg;

  localparam int unsigned MAX_POINTS = 65536;
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS);
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int unsigned MUL_W      = 35;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned ACC_W      = 66;
  localparam int unsigned T_W        = 35;
  localparam int unsigned PADDR_W    = 5;

  localparam logic [31:0]        SAT32       = 32'hFFFF_FFFF;
  localparam logic signed [31:0] DIR_ONE     = 32'sh4000_0000;
  localparam logic signed [31:0] DIR_NEG_ONE = -32'sh4000_0000;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;
  } point_in_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] best_index;
    logic [31:0]      perp_distance;
    logic [31:0]      along_ray;
  } pick_out_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [31:0]        threshold_tangent;
    logic [30:0]        max_range;
  } cfg_t;

  // one queued point: offset from the ray origin plus bookkeeping
  typedef struct packed {
    logic signed [32:0] d_x;
    logic signed [32:0] d_y;
    logic signed [32:0] d_z;
    logic [IDX_W-1:0]   idx;
    logic               last;
  } qentry_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_DIR_X     = 3'd3,
    REG_DIR_Y     = 3'd4,
    REG_DIR_Z     = 3'd5,
    REG_THRESHOLD = 3'd6,
    REG_MAX_RANGE = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT,
    ST_TSUM,
    ST_TCHK,
    ST_SCALE,
    ST_SQ,
    ST_ROOT,
    ST_MUL_A,
    ST_MUL_B,
    ST_DECIDE,
    ST_FINISH
  } back_state_e;

endpackage

[sv/nearest_point_to_ray_pick.sv]
// nearest_point_to_ray_pick: top level with APB register file, front,
// queue and back sequencer. Depends on npr_pkg, npr_front, npr_queue, npr_back.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_ready_o   | in_data_i  (point_in_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (pick_out_t)
//   cfg     | input     | psel, penable, pwrite     | paddr, pwdata, prdata
//
// Points are handled one at a time by the back sequencer around one shared
// 35x35 multiplier; a skipped point goes from the t check to the finish
// state, and a saturated residual bypasses the bit-serial square root.
// The front queues up to two points ahead, and a finished result waits in
// the output register while later points go on; a closing point waits till
// it is taken. Reset is asynchronous; it sets control and config to defaults.
module nearest_point_to_ray_pick (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  npr_pkg::point_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output npr_pkg::pick_out_t             out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [npr_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import npr_pkg::*;

  cfg_t               cfg_q;
  reg_idx_e           reg_idx;
  logic               wr_en;
  logic signed [31:0] dir_clamped;
  logic               q_full, q_empty, q_push, q_pop;
  qentry_t            q_in, q_out;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    dir_clamped = $signed(pwdata);
    if ($signed(pwdata) > DIR_ONE) begin
      dir_clamped = DIR_ONE;
    end else if ($signed(pwdata) < DIR_NEG_ONE) begin
      dir_clamped = DIR_NEG_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x          <= '0;
      cfg_q.origin_y          <= '0;
      cfg_q.origin_z          <= '0;
      cfg_q.dir_x             <= '0;
      cfg_q.dir_y             <= '0;
      cfg_q.dir_z             <= DIR_ONE;
      cfg_q.threshold_tangent <= '0;
      cfg_q.max_range         <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ORIGIN_X:  cfg_q.origin_x          <= $signed(pwdata);
        REG_ORIGIN_Y:  cfg_q.origin_y          <= $signed(pwdata);
        REG_ORIGIN_Z:  cfg_q.origin_z          <= $signed(pwdata);
        REG_DIR_X:     cfg_q.dir_x             <= dir_clamped;
        REG_DIR_Y:     cfg_q.dir_y             <= dir_clamped;
        REG_DIR_Z:     cfg_q.dir_z             <= dir_clamped;
        REG_THRESHOLD: cfg_q.threshold_tangent <= pwdata;
        REG_MAX_RANGE: cfg_q.max_range         <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X:  prdata = cfg_q.origin_x;
      REG_ORIGIN_Y:  prdata = cfg_q.origin_y;
      REG_ORIGIN_Z:  prdata = cfg_q.origin_z;
      REG_DIR_X:     prdata = cfg_q.dir_x;
      REG_DIR_Y:     prdata = cfg_q.dir_y;
      REG_DIR_Z:     prdata = cfg_q.dir_z;
      REG_THRESHOLD: prdata = cfg_q.threshold_tangent;
      REG_MAX_RANGE: prdata = {1'b0, cfg_q.max_range};
      default:       prdata = '0;
    endcase
  end

  npr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_in)
  );

  npr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  npr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_entry_i   (q_out),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/npr_front.sv]
// npr_front: accepts point transactions, forms the offset from the ray origin
// and tags each point with its stream position. Depends on npr_pkg.
module npr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  npr_pkg::point_in_t in_data_i,
  input  npr_pkg::cfg_t      cfg_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output npr_pkg::qentry_t   q_entry_o
);
  import npr_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_entry_o.d_x  = 33'(in_data_i.point_x) - 33'(cfg_i.origin_x);
    q_entry_o.d_y  = 33'(in_data_i.point_y) - 33'(cfg_i.origin_y);
    q_entry_o.d_z  = 33'(in_data_i.point_z) - 33'(cfg_i.origin_z);
    q_entry_o.idx  = IDX_W'(cnt_q);
    q_entry_o.last = in_data_i.last_point;
  end

  // position wraps at the stream limit and restarts after the closing point
  always_comb begin
    cnt_d = cnt_q;
    if (q_push_o) begin
      if (in_data_i.last_point || cnt_q == CNT_W'(MAX_POINTS - 1)) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[sv/npr_queue.sv]
// npr_queue: short FIFO of offset points between front and back.
// Depends on npr_pkg for the entry type and depth.
module npr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  npr_pkg::qentry_t entry_i,
  input  logic             pop_i,
  output npr_pkg::qentry_t entry_o,
  output logic             full_o,
  output logic             empty_o
);
  import npr_pkg::*;

  qentry_t            mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_q, rptr_q;
  logic [Q_CNT_W-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[sv/npr_isqrt.sv]
// npr_isqrt: 64-bit integer square root, one result bit per cycle (32 steps).
// Depends on npr_pkg only by convention; no shared types used.
module npr_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import npr_pkg::*;

  logic [63:0] rem_q, res_q, bit_w, trial_w;
  logic [4:0]  step_q;
  logic        busy_q, done_q;

  assign bit_w   = 64'd1 << (6'd62 - {step_q, 1'b0});
  assign trial_w = res_q + bit_w;
  assign done_o  = done_q;
  assign root_o  = res_q[31:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= radicand_i;
      res_q <= '0;
    end else if (busy_q) begin
      if (rem_q >= trial_w) begin
        rem_q <= rem_q - trial_w;
        res_q <= (res_q >> 1) + bit_w;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/npr_back.sv]
// npr_back: sequencer that projects each queued point on the ray, finds its
// distance via npr_isqrt and keeps the best candidate. Depends on npr_pkg.
module npr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  npr_pkg::cfg_t      cfg_i,
  input  npr_pkg::qentry_t   q_entry_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output npr_pkg::pick_out_t out_data_o
);
  import npr_pkg::*;

  back_state_e state_q, state_d;
  logic [1:0]  cnt_q, cnt_d;

  logic signed [32:0]       d_q [3];
  logic [IDX_W-1:0]         idx_q;
  logic                     last_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [T_W-1:0]    t_q;
  logic [31:0]              tc_q, a_q [3];
  logic                     asat_q;
  logic [63:0]              sum_q, sum_d, lhs_q;
  logic                     ssat_q, ssat_d;
  logic [31:0]              perp_q;

  logic             have_best_q;
  logic [IDX_W-1:0] best_pos_q;
  logic [31:0]      best_perp_q, best_along_q;

  pick_out_t out_q;
  logic      out_valid_q;

  logic               sq_start;
  logic               root_done;
  logic [31:0]        root_w;
  logic signed [32:0] d_cur, d_prev;
  logic signed [31:0] dir_cur, dir_prev, absdir_cur;
  logic [31:0]        a_cur;
  logic signed [35:0] t_full;
  logic               t_skip;
  logic [64:0]        round_w, sq_sum_w;
  logic signed [35:0] c_w;
  logic signed [36:0] r_w, ra_w;
  logic               r_sat;
  logic [63:0]        rhs_w;
  logic               accept_w;
  logic               out_free;

  npr_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sum_d),
    .done_o     (root_done),
    .root_o     (root_w)
  );

  // operand selection for the current and the previous component
  always_comb begin
    unique case (cnt_q)
      2'd0:    begin d_cur = d_q[0]; dir_cur = cfg_i.dir_x; a_cur = a_q[0]; end
      2'd1:    begin d_cur = d_q[1]; dir_cur = cfg_i.dir_y; a_cur = a_q[1]; end
      default: begin d_cur = d_q[2]; dir_cur = cfg_i.dir_z; a_cur = a_q[2]; end
    endcase
    unique case (cnt_q)
      2'd1:    begin d_prev = d_q[0]; dir_prev = cfg_i.dir_x; end
      2'd2:    begin d_prev = d_q[1]; dir_prev = cfg_i.dir_y; end
      default: begin d_prev = d_q[2]; dir_prev = cfg_i.dir_z; end
    endcase
    absdir_cur = (dir_cur < 0) ? -dir_cur : dir_cur;
  end

  // t and the skip test
  always_comb begin
    t_full = acc_q[ACC_W-1:30];
    t_skip = (t_full <= 36'sd0) ||
             ((cfg_i.max_range != '0) && (t_full > $signed({5'd0, cfg_i.max_range})));
  end

  // residual of one component: d - round(dir * t / 2^30), ties away from zero
  always_comb begin
    round_w = {1'b0, prod_q[63:0]} + 65'd536870912;
    c_w     = (dir_prev < 0) ? -$signed({1'b0, round_w[64:30]})
                             : $signed({1'b0, round_w[64:30]});
    r_w     = 37'(d_prev) - 37'(c_w);
    ra_w    = (r_w < 0) ? -r_w : r_w;
    r_sat   = (ra_w[36:32] != '0);
  end

  // sum of squares with overflow flag at 2^64
  always_comb begin
    sq_sum_w = {1'b0, sum_q} + {1'b0, prod_q[63:0]};
    sum_d    = sum_q;
    ssat_d   = ssat_q;
    if (state_q == ST_SQ) begin
      if (cnt_q == 2'd0) begin
        sum_d  = '0;
        ssat_d = 1'b0;
      end else begin
        sum_d  = sq_sum_w[63:0];
        ssat_d = ssat_q | sq_sum_w[64];
      end
    end
  end

  // candidate decision; lhs_q holds threshold*tc when no best exists yet
  always_comb begin
    rhs_w = prod_q[63:0];
    if (!have_best_q) begin
      accept_w = (cfg_i.threshold_tangent == SAT32) || ({16'd0, perp_q, 16'd0} <= lhs_q);
    end else begin
      accept_w = (lhs_q < rhs_w) || ((lhs_q == rhs_w) && (tc_q < best_along_q));
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ST_DOT;
          cnt_d   = 2'd0;
        end
      end
      ST_DOT: begin
        if (cnt_q == 2'd2) begin
          state_d = ST_TSUM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_TSUM: state_d = ST_TCHK;
      ST_TCHK: begin
        state_d = t_skip ? ST_FINISH : ST_SCALE;
        cnt_d   = 2'd0;
      end
      ST_SCALE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 2'd3) begin
          state_d = ST_SQ;
          cnt_d   = 2'd0;
        end
      end
      ST_SQ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 2'd3) begin
          state_d = (ssat_d || asat_q) ? ST_MUL_A : ST_ROOT;
          cnt_d   = 2'd0;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A:  state_d = ST_MUL_B;
      ST_MUL_B:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!last_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: queue pop, root start, multiplier operands
  always_comb begin
    q_pop_o  = 1'b0;
    sq_start = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_q)
      ST_IDLE: q_pop_o = !q_empty_i;
      ST_DOT: begin
        mul_a = MUL_W'(d_cur);
        mul_b = MUL_W'(dir_cur);
      end
      ST_SCALE: begin
        if (cnt_q != 2'd3) begin
          mul_a = $signed({4'd0, absdir_cur[30:0]});
          mul_b = t_q;
        end
      end
      ST_SQ: begin
        if (cnt_q != 2'd3) begin
          mul_a = $signed({3'd0, a_cur});
          mul_b = $signed({3'd0, a_cur});
        end else begin
          sq_start = !(ssat_d || asat_q);
        end
      end
      ST_MUL_A: begin
        mul_a = $signed({3'd0, have_best_q ? perp_q : cfg_i.threshold_tangent});
        mul_b = $signed({3'd0, have_best_q ? best_along_q : tc_q});
      end
      ST_MUL_B: begin
        mul_a = $signed({3'd0, best_perp_q});
        mul_b = $signed({3'd0, tc_q});
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      ST_IDLE: begin
        d_q[0] <= q_entry_i.d_x;
        d_q[1] <= q_entry_i.d_y;
        d_q[2] <= q_entry_i.d_z;
        idx_q  <= q_entry_i.idx;
        last_q <= q_entry_i.last;
      end
      ST_DOT: begin
        acc_q <= (cnt_q == 2'd0) ? '0 : acc_q + ACC_W'(prod_q);
      end
      ST_TSUM: acc_q <= acc_q + ACC_W'(prod_q);
      ST_TCHK: begin
        t_q    <= t_full[T_W-1:0];
        tc_q   <= (t_full > 36'sd4294967295) ? SAT32 : t_full[31:0];
        asat_q <= 1'b0;
      end
      ST_SCALE: begin
        if (cnt_q != 2'd0) begin
          a_q[cnt_q - 2'd1] <= ra_w[31:0];
          asat_q            <= asat_q | r_sat;
        end
      end
      ST_SQ: begin
        sum_q  <= sum_d;
        ssat_q <= ssat_d;
        if (cnt_q == 2'd3) begin
          perp_q <= SAT32;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          perp_q <= root_w;
        end
      end
      ST_MUL_B: lhs_q <= prod_q[63:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      have_best_q  <= 1'b0;
      best_pos_q   <= '0;
      best_perp_q  <= '0;
      best_along_q <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_DECIDE && accept_w) begin
        have_best_q  <= 1'b1;
        best_pos_q   <= idx_q;
        best_perp_q  <= perp_q;
        best_along_q <= tc_q;
      end
      if (state_q == ST_FINISH && last_q && out_free) begin
        out_valid_q         <= 1'b1;
        out_q.hit           <= have_best_q;
        out_q.best_index    <= have_best_q ? best_pos_q : '0;
        out_q.perp_distance <= have_best_q ? best_perp_q : '0;
        out_q.along_ray     <= have_best_q ? best_along_q : '0;
        have_best_q         <= 1'b0;
        best_pos_q          <= '0;
        best_perp_q         <= '0;
        best_along_q        <= '0;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i)
    else $error("queue popped while empty");

  a_result_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(last_q) && !have_best_q)
    else $error("result without closing point or best not cleared");

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.hit) |->
      (out_q.best_index == '0 && out_q.perp_distance == '0 && out_q.along_ray == '0))
    else $error("miss result carries non-zero fields");

  a_best_positive_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_best_q |-> best_along_q != '0)
    else $error("best candidate with zero t");

endmodule

[verif/nearest_point_to_ray_pick_tb.sv]
// Self-checking testbench for nearest_point_to_ray_pick: points through the
// valid/ready stream, ray settings by APB, pick results checked against a
// behavioural predictor. Depends on npr_pkg and the block's RTL.
module nearest_point_to_ray_pick_tb;
  import npr_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  point_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pick_out_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nearest_point_to_ray_pick dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  longint org_x, org_y, org_z, dr_x, dr_y, dr_z;
  longint unsigned thr_tan, range_lim;
  int unsigned pos_cnt;
  bit have_pick;
  int unsigned pick_pos;
  longint unsigned pick_perp, pick_t;

  point_in_t point_q[$];
  pick_out_t pick_q[$];
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  int unsigned mismatches = 0, picks_seen = 0, hits_seen = 0, points_sent = 0;

  function automatic longint clamp_unit(logic [31:0] v);
    longint s = longint'($signed(v));
    if (s > 64'sd1073741824) return 64'sd1073741824;
    if (s < -64'sd1073741824) return -64'sd1073741824;
    return s;
  endfunction

  function automatic longint unsigned root64(longint unsigned s);
    longint unsigned res = 0, b;
    for (int i = 0; i < 32; i++) begin
      b = 64'd1 << (62 - 2 * i);
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
    end
    return res;
  endfunction

  // rounded dir*t/2^30, ties away from zero
  function automatic longint along_dir(longint d, longint t);
    longint unsigned m, q;
    m = longint'(d < 0 ? -d : d) * longint'(t);
    q = (m + (64'd1 << 29)) >> 30;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic set_reg(reg_idx_e r, logic [31:0] v);
    case (r)
      REG_ORIGIN_X:  org_x = longint'($signed(v));
      REG_ORIGIN_Y:  org_y = longint'($signed(v));
      REG_ORIGIN_Z:  org_z = longint'($signed(v));
      REG_DIR_X:     dr_x = clamp_unit(v);
      REG_DIR_Y:     dr_y = clamp_unit(v);
      REG_DIR_Z:     dr_z = clamp_unit(v);
      REG_THRESHOLD: thr_tan = v;
      REG_MAX_RANGE: range_lim = v[30:0];
      default: ;
    endcase
  endtask

  task automatic pick_step(point_in_t p);
    longint d[3], dv[3], t, r;
    logic signed [127:0] acc;
    longint unsigned sum, a, sq, perp, tc, lhs, rhs;
    bit sat;
    pick_out_t res;
    d[0] = longint'(p.point_x) - org_x;
    d[1] = longint'(p.point_y) - org_y;
    d[2] = longint'(p.point_z) - org_z;
    dv[0] = dr_x; dv[1] = dr_y; dv[2] = dr_z;
    acc = 0;
    for (int i = 0; i < 3; i++) acc += 128'(d[i]) * 128'(dv[i]);
    t = longint'(acc >>> 30);
    if (t > 0 && !(range_lim != 0 && t > longint'(range_lim))) begin
      sat = 0; sum = 0;
      for (int i = 0; i < 3; i++) begin
        r = d[i] - along_dir(dv[i], t);
        a = r < 0 ? -r : r;
        if (a > 64'hFFFF_FFFF) sat = 1;
        else begin
          sq = a * a;
          if (sum > ~64'd0 - sq) sat = 1;
          else sum += sq;
        end
      end
      perp = sat ? 64'hFFFF_FFFF : root64(sum);
      tc = t > 64'sh0_FFFF_FFFF ? 64'hFFFF_FFFF : t;
      if (!have_pick) begin
        if (thr_tan == 64'hFFFF_FFFF || (perp << 16) <= thr_tan * tc) begin
          have_pick = 1; pick_pos = pos_cnt; pick_perp = perp; pick_t = tc;
        end
      end else begin
        lhs = perp * pick_t;
        rhs = pick_perp * tc;
        if (lhs < rhs || (lhs == rhs && tc < pick_t)) begin
          pick_pos = pos_cnt; pick_perp = perp; pick_t = tc;
        end
      end
    end
    pos_cnt = (pos_cnt + 1 >= MAX_POINTS) ? 0 : pos_cnt + 1;
    if (p.last_point) begin
      res = '0;
      if (have_pick) begin
        res.hit = 1'b1;
        res.best_index = pick_pos[15:0];
        res.perp_distance = pick_perp[31:0];
        res.along_ray = pick_t[31:0];
      end
      pick_q.push_back(res);
      pos_cnt = 0; have_pick = 0; pick_pos = 0; pick_perp = 0; pick_t = 0;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pick_step(in_data_i);
        points_sent++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i <= point_q.pop_front();
          in_valid_i <= 1'b1;
        end else in_valid_i <= 1'b0;
      end
      out_ready_i <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      picks_seen++;
      if (pick_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        if (pick_q[0].hit) hits_seen++;
        if (out_data_o !== pick_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0d idx=%0d perp=%h t=%h got hit=%0d idx=%0d perp=%h t=%h",
                     pick_q[0].hit, pick_q[0].best_index, pick_q[0].perp_distance,
                     pick_q[0].along_ray, out_data_o.hit, out_data_o.best_index,
                     out_data_o.perp_distance, out_data_o.along_ray);
        end
        void'(pick_q.pop_front());
      end
    end
  end

  task automatic apb_write(reg_idx_e r, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(r)); pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    set_reg(r, v);
  endtask

  task automatic drain();
    while (point_q.size() != 0 || in_valid_i || pick_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic point_in_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit l);
    point_in_t p;
    p.point_x = x; p.point_y = y; p.point_z = z; p.last_point = l;
    return p;
  endfunction

  // coordinates mostly within 2^22 of zero, sometimes anywhere
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
    endcase
  endfunction

  task automatic rand_set(int n);
    for (int i = 0; i < n; i++)
      point_q.push_back(mk(rand_coord(), rand_coord(), rand_coord(), i == n - 1));
  endtask

  task automatic rand_cfg();
    apb_write(REG_ORIGIN_X, $urandom_range(3) == 0 ? $urandom : 32'($signed($urandom_range(2000000)) - 1000000));
    apb_write(REG_ORIGIN_Y, $urandom_range(3) == 0 ? $urandom : 32'($signed($urandom_range(2000000)) - 1000000));
    apb_write(REG_ORIGIN_Z, $urandom_range(3) == 0 ? $urandom : 32'($signed($urandom_range(2000000)) - 1000000));
    apb_write(REG_DIR_X, $urandom_range(4) == 0 ? $urandom : 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000));
    apb_write(REG_DIR_Y, 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000));
    apb_write(REG_DIR_Z, 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000));
    case ($urandom_range(3))
      0: apb_write(REG_THRESHOLD, 32'hFFFF_FFFF);
      1: apb_write(REG_THRESHOLD, $urandom);
      default: apb_write(REG_THRESHOLD, $urandom_range(32'h0004_0000));
    endcase
    apb_write(REG_MAX_RANGE, $urandom_range(1) ? 0 : $urandom_range(32'h7FFF_FFFF));
  endtask

  initial begin
    int budget;
    org_x = 0; org_y = 0; org_z = 0; dr_x = 0; dr_y = 0; dr_z = 64'sd1073741824;
    thr_tan = 0; range_lim = 0; pos_cnt = 0; have_pick = 0;
    pick_pos = 0; pick_perp = 0; pick_t = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset ray along +z, points behind, on, near and far
    apb_write(REG_THRESHOLD, 32'h0001_0000);
    point_q.push_back(mk(0, 0, 32'hFFFF_0000, 0));        // behind origin
    point_q.push_back(mk(0, 0, 0, 0));                    // t of zero
    point_q.push_back(mk(32'h0000_8000, 0, 32'h0002_0000, 0));
    point_q.push_back(mk(0, 0, 32'h0004_0000, 0));        // on the ray
    point_q.push_back(mk(32'h0000_4000, 0, 32'h0000_4000, 1)); // perp/t ratio equal to the threshold
    point_q.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1));
    point_q.push_back(mk(0, 0, 32'hFFFF_FFFF, 1));        // no hit
    drain();
    apb_write(REG_DIR_X, 32'h7FFF_FFFF);                  // saturates to +1.0
    apb_write(REG_DIR_Z, 32'h8000_0000);                  // saturates to -1.0
    apb_write(REG_ORIGIN_X, 32'h8000_0000);
    apb_write(REG_ORIGIN_Y, 32'h7FFF_FFFF);
    apb_write(REG_ORIGIN_Z, 32'h8000_0000);
    apb_write(REG_DIR_Y, 32'hC000_0000);
    apb_write(REG_THRESHOLD, 32'hFFFF_FFFF);
    apb_write(REG_MAX_RANGE, 32'h7FFF_FFFF);
    point_q.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0)); // far point
    point_q.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    point_q.push_back(mk(32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFE, 1));
    drain();
    apb_write(REG_MAX_RANGE, 32'h0010_0000);
    point_q.push_back(mk(32'h7FFF_FFFF, 0, 0, 0));        // beyond range
    point_q.push_back(mk(32'h8000_0000, 0, 0, 0));
    point_q.push_back(mk(32'h0008_0000, 0, 0, 1));
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      rand_cfg();
      budget = 0;
      while (budget < 230) begin
        int n;
        n = $urandom_range(15) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 8);
        rand_set(n);
        budget += n;
        if (ph == 3 && budget > 100 && budget < 110) begin
          while (point_q.size() != 0 || in_valid_i || pick_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("%0d points sent, %0d results checked (%0d hits), %0d mismatches",
             points_sent, picks_seen, hits_seen, mismatches);
    $display("covered far points, range limits, saturated directions, tie breaks, stalls");
    if (mismatches == 0 && pick_q.size() == 0) $display("nearest_point_to_ray_pick_tb passed");
    else $display("nearest_point_to_ray_pick_tb failed");
    $finish;
  end

  initial begin
    #40000000;
    $display("nearest_point_to_ray_pick_tb failed");
    $finish;
  end
endmodule
